// File: hdl/cbt_pkg.sv
// ----------------------------------------------------------------------------
// cbt_pkg
// Shared types and constants for the CJK bigram tokenizer.
// ----------------------------------------------------------------------------
package cbt_pkg;

    // Offset width on the token ports.
    localparam int TOK_OFF_W = 16;

    // Token kind codes as seen on token_kind.
    typedef enum logic [1:0] {
        KIND_WORD   = 2'd0,
        KIND_DIGIT  = 2'd1,
        KIND_BIGRAM = 2'd2
    } kind_t;

    // Open ASCII run, one-hot.
    typedef enum logic [2:0] {
        RUN_NONE  = 3'b001,
        RUN_WORD  = 3'b010,
        RUN_DIGIT = 3'b100
    } run_t;

    typedef struct packed {
        kind_t                  kind;
        logic [TOK_OFF_W-1:0]   tok_start;
        logic [TOK_OFF_W-1:0]   tok_end;
        logic                   ovf;
    } token_t;

    // One queue entry: all tokens caused by one byte (one or two).
    typedef struct packed {
        logic   two_tokens;
        token_t tok0;
        token_t tok1;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    // Stop punctuation code points (shortest encoding only).
    localparam int NUM_STOP = 14;
    localparam logic [15:0] STOP_POINTS [NUM_STOP] = '{
        16'h00B7, 16'h3001, 16'h3002, 16'h300A, 16'h300B, 16'h300C, 16'hFF01,
        16'hFF08, 16'hFF09, 16'hFF0C, 16'hFF1A, 16'hFF1B, 16'hFF1F, 16'hFFE5
    };

    // Code point below which a stop char is a two-byte sequence.
    localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;

    function automatic logic is_stop_point(input logic [15:0] cp);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < NUM_STOP; i++)
        begin
            if (cp == STOP_POINTS[i])
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic kind_t run_kind(input run_t run);
        return (run == RUN_WORD) ? KIND_WORD : KIND_DIGIT;
    endfunction

endpackage

// File: hdl/cjk_bigram_tokenizer_top.sv
// ----------------------------------------------------------------------------
// cjk_bigram_tokenizer_top
// UTF-8 byte stream in, word / number / CJK bigram tokens out as offsets.
// ----------------------------------------------------------------------------
// One document byte enters per cycle on the input channel while in_stall is
// low; end_of_document marks the last byte and clears all state after it.
// The front classifies each byte and updates the decoder and run state in
// the same cycle, so input never waits on the document itself. Each byte
// yields zero, one or two tokens; the tokens of one byte travel together as
// one entry through a QUEUE_DEPTH-entry queue to the output stage, which
// presents them one per cycle while out_stall is low, last_of_item marking
// the final token of that byte. The output port is therefore the bottleneck
// when bytes yield two tokens, and the queue soaks up short bursts of those.
// A token passes through its queue slot and then the output register. Input
// stall rises only when the queue is full. Offsets count bytes from the
// start of the document, saturate at 2^OFFSET_BITS-1 (offset_overflow is
// then set on all later tokens of that document) and show on the ports as
// their low 16 bits. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module cjk_bigram_tokenizer_top #(
    parameter int OFFSET_BITS   = 16,
    parameter int MAX_SEQ_BYTES = 6,
    parameter int QUEUE_DEPTH   = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // byte input
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    data_byte,
    input  logic                          end_of_document,
    // token output
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    token_kind,
    output logic [cbt_pkg::TOK_OFF_W-1:0] token_start,
    output logic [cbt_pkg::TOK_OFF_W-1:0] token_end,
    output logic                          offset_overflow,
    output logic                          last_of_item
);

    localparam int EntryW = $bits(cbt_pkg::entry_t);

    logic                  in_fire;
    logic                  fifo_push;
    logic                  fifo_pop;
    cbt_pkg::entry_t       push_entry;
    cbt_pkg::entry_t       head_entry;
    logic [EntryW-1:0]     head_bits;
    cbt_pkg::fifo_status_t fifo_st;

    assign in_stall   = fifo_st.full;
    assign in_fire    = in_valid && !in_stall;
    assign head_entry = cbt_pkg::entry_t'(head_bits);

    // Front: classify, decode UTF-8, track runs, build token entries.
    cbt_front #(
        .OFFSET_BITS   (OFFSET_BITS),
        .MAX_SEQ_BYTES (MAX_SEQ_BYTES)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_fire         (in_fire),
        .data_byte       (data_byte),
        .end_of_document (end_of_document),
        .push            (fifo_push),
        .push_entry      (push_entry)
    );

    // Queue decouples byte intake from token output.
    cbt_fifo #(
        .WIDTH (EntryW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .push_data (EntryW'(push_entry)),
        .pop       (fifo_pop),
        .head_data (head_bits),
        .status    (fifo_st)
    );

    // Back: one token per output handshake.
    cbt_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_entry      (head_entry),
        .head_valid      (!fifo_st.empty),
        .pop             (fifo_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .token_kind      (token_kind),
        .token_start     (token_start),
        .token_end       (token_end),
        .offset_overflow (offset_overflow),
        .last_of_item    (last_of_item)
    );

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // queue never written while full
    assert property (@(posedge clk) disable iff (!rst_n)
        fifo_push |-> !fifo_st.full)
        else $error("token queue written while full");

    // queue never read while empty
    assert property (@(posedge clk) disable iff (!rst_n)
        fifo_pop |-> !fifo_st.empty)
        else $error("token queue read while empty");

    // second token of a byte follows right after the first
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_of_item) |=> (out_valid && last_of_item))
        else $error("second token of a byte missing");

    // both tokens of one byte carry the same overflow flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_of_item) |=>
            (offset_overflow == $past(offset_overflow)))
        else $error("overflow flag differs within one byte");

endmodule

// File: hdl/cbt_front.sv
// ----------------------------------------------------------------------------
// cbt_front
// Byte classifier and UTF-8 decoder; builds one queue entry per byte that
// yields tokens.
// ----------------------------------------------------------------------------
module cbt_front #(
    parameter int OFFSET_BITS   = 16,
    parameter int MAX_SEQ_BYTES = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic [7:0]        data_byte,
    input  logic              end_of_document,
    output logic              push,
    output cbt_pkg::entry_t   push_entry
);

    localparam int AccW  = 5 * MAX_SEQ_BYTES + 1;
    localparam int PendW = $clog2(MAX_SEQ_BYTES);
    localparam int LenW  = $clog2(MAX_SEQ_BYTES + 1);
    localparam int ExtW  = (OFFSET_BITS > cbt_pkg::TOK_OFF_W) ? OFFSET_BITS
                                                              : cbt_pkg::TOK_OFF_W;

    function automatic logic [cbt_pkg::TOK_OFF_W-1:0] to_tok(
        input logic [OFFSET_BITS-1:0] v);
        logic [ExtW-1:0] e;
        e = ExtW'(v);
        return e[cbt_pkg::TOK_OFF_W-1:0];
    endfunction

    // Sequence length from a lead byte; 0 for stray or too-long leads.
    function automatic logic [LenW-1:0] lead_length(input logic [7:0] b);
        int len;
        len = 0;
        priority if ((b & 8'hE0) == 8'hC0) len = 2;
        else if ((b & 8'hF0) == 8'hE0)     len = 3;
        else if ((b & 8'hF8) == 8'hF0)     len = 4;
        else if ((b & 8'hFC) == 8'hF8)     len = 5;
        else if ((b & 8'hFE) == 8'hFC)     len = 6;
        else                               len = 0;
        if (len > MAX_SEQ_BYTES)
        begin
            len = 0;
        end
        return LenW'(len);
    endfunction

    logic [OFFSET_BITS-1:0] pos_reg,        pos_next;
    cbt_pkg::run_t          run_reg,        run_next;
    logic [OFFSET_BITS-1:0] run_start_reg,  run_start_next;
    logic [OFFSET_BITS-1:0] prev_start_reg, prev_start_next;
    logic                   have_prev_reg,  have_prev_next;
    logic [OFFSET_BITS-1:0] char_start_reg, char_start_next;
    logic [PendW-1:0]       pend_reg,       pend_next;
    logic [LenW-1:0]        seq_len_reg,    seq_len_next;
    logic [AccW-1:0]        acc_reg,        acc_next;
    logic                   ovf_reg,        ovf_next;

    always_comb
    begin
        logic                   sat;
        logic [OFFSET_BITS-1:0] cur;
        logic [OFFSET_BITS-1:0] nxt;
        logic                   ovf;
        logic                   digit;
        logic                   space;
        logic                   alpha;
        logic                   keeps;
        logic                   stop;
        logic [LenW-1:0]        len;
        logic                   a_v;
        logic                   b_v;
        logic                   c_v;
        cbt_pkg::token_t        tok_a;
        cbt_pkg::token_t        tok_b;
        cbt_pkg::token_t        tok_c;

        sat = (pos_reg == {OFFSET_BITS{1'b1}});
        cur = pos_reg;
        nxt = sat ? pos_reg : pos_reg + 1'b1;
        ovf = ovf_reg | sat;

        run_next        = run_reg;
        run_start_next  = run_start_reg;
        prev_start_next = prev_start_reg;
        have_prev_next  = have_prev_reg;
        char_start_next = char_start_reg;
        pend_next       = pend_reg;
        seq_len_next    = seq_len_reg;
        acc_next        = acc_reg;
        ovf_next        = ovf;

        digit = (data_byte >= 8'h30) && (data_byte <= 8'h39);
        space = (data_byte == 8'h20) || ((data_byte >= 8'h09) && (data_byte <= 8'h0D));
        alpha = ((data_byte >= 8'h41) && (data_byte <= 8'h5A)) ||
                ((data_byte >= 8'h61) && (data_byte <= 8'h7A));
        keeps = ((run_reg == cbt_pkg::RUN_WORD) && !digit && !space) ||
                ((run_reg == cbt_pkg::RUN_DIGIT) && digit);
        len   = lead_length(data_byte);
        stop  = 1'b0;
        a_v   = 1'b0;
        b_v   = 1'b0;
        c_v   = 1'b0;

        // run-close token: from the old run state
        tok_a.kind      = cbt_pkg::run_kind(run_reg);
        tok_a.tok_start = to_tok(run_start_reg);
        tok_a.tok_end   = to_tok(cur);
        tok_a.ovf       = ovf;

        // bigram token: previous char through the end of this one
        tok_b.kind      = cbt_pkg::KIND_BIGRAM;
        tok_b.tok_start = to_tok(prev_start_reg);
        tok_b.tok_end   = to_tok(nxt);
        tok_b.ovf       = ovf;

        if (!data_byte[7])
        begin
            pend_next      = '0;
            have_prev_next = 1'b0;
            if ((run_reg != cbt_pkg::RUN_NONE) && !keeps)
            begin
                a_v      = 1'b1;
                run_next = cbt_pkg::RUN_NONE;
            end
            if (run_next == cbt_pkg::RUN_NONE)
            begin
                if (alpha)
                begin
                    run_next       = cbt_pkg::RUN_WORD;
                    run_start_next = cur;
                end
                else if (digit)
                begin
                    run_next       = cbt_pkg::RUN_DIGIT;
                    run_start_next = cur;
                end
            end
        end
        else
        begin
            if (run_reg != cbt_pkg::RUN_NONE)
            begin
                a_v      = 1'b1;
                run_next = cbt_pkg::RUN_NONE;
            end
            if (data_byte[7:6] == 2'b10)
            begin
                if (pend_reg != '0)
                begin
                    acc_next  = {acc_reg[AccW-7:0], data_byte[5:0]};
                    pend_next = pend_reg - 1'b1;
                    if (pend_next == '0)
                    begin
                        stop = cbt_pkg::is_stop_point(acc_next[15:0]) &&
                               (acc_next[AccW-1:16] == '0) &&
                               (seq_len_reg == ((acc_next[15:0] < cbt_pkg::TWO_BYTE_LIMIT)
                                                ? LenW'(2) : LenW'(3)));
                        if (stop)
                        begin
                            have_prev_next = 1'b0;
                        end
                        else
                        begin
                            b_v             = have_prev_reg;
                            prev_start_next = char_start_reg;
                            have_prev_next  = 1'b1;
                        end
                    end
                end
                else
                begin
                    have_prev_next = 1'b0;
                end
            end
            else
            begin
                // lead byte; an open sequence is cut off
                if (pend_reg != '0)
                begin
                    pend_next      = '0;
                    have_prev_next = 1'b0;
                end
                if (len != '0)
                begin
                    char_start_next = cur;
                    seq_len_next    = len;
                    pend_next       = PendW'(len - 1'b1);
                    acc_next        = AccW'(data_byte & (8'h7F >> len));
                end
                else
                begin
                    have_prev_next = 1'b0;
                end
            end
        end

        pos_next = nxt;

        // end of document closes an open ASCII run just past this byte
        tok_c.kind      = cbt_pkg::run_kind(run_next);
        tok_c.tok_start = to_tok(run_start_next);
        tok_c.tok_end   = to_tok(nxt);
        tok_c.ovf       = ovf;

        if (end_of_document)
        begin
            c_v             = (run_next != cbt_pkg::RUN_NONE);
            pos_next        = '0;
            run_next        = cbt_pkg::RUN_NONE;
            run_start_next  = '0;
            prev_start_next = '0;
            have_prev_next  = 1'b0;
            char_start_next = '0;
            pend_next       = '0;
            seq_len_next    = '0;
            acc_next        = '0;
            ovf_next        = 1'b0;
        end

        // pack in order: run close, bigram, end-of-document close
        push                  = in_fire && (a_v || b_v || c_v);
        push_entry.two_tokens = (a_v && b_v) || (a_v && c_v) || (b_v && c_v);
        push_entry.tok0       = a_v ? tok_a : (b_v ? tok_b : tok_c);
        push_entry.tok1       = (a_v && b_v) ? tok_b : tok_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            run_reg        <= cbt_pkg::RUN_NONE;
            run_start_reg  <= '0;
            prev_start_reg <= '0;
            have_prev_reg  <= 1'b0;
            char_start_reg <= '0;
            pend_reg       <= '0;
            seq_len_reg    <= '0;
            acc_reg        <= '0;
            ovf_reg        <= 1'b0;
        end
        else if (in_fire)
        begin
            pos_reg        <= pos_next;
            run_reg        <= run_next;
            run_start_reg  <= run_start_next;
            prev_start_reg <= prev_start_next;
            have_prev_reg  <= have_prev_next;
            char_start_reg <= char_start_next;
            pend_reg       <= pend_next;
            seq_len_reg    <= seq_len_next;
            acc_reg        <= acc_next;
            ovf_reg        <= ovf_next;
        end
    end

endmodule

// File: hdl/cbt_fifo.sv
// ----------------------------------------------------------------------------
// cbt_fifo
// Small register queue between classifier and token output.
// ----------------------------------------------------------------------------
module cbt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [WIDTH-1:0]      push_data,
    input  logic                  pop,
    output logic [WIDTH-1:0]      head_data,
    output cbt_pkg::fifo_status_t status
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg,  count_next;

    assign status.full  = (count_reg == CntW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_data    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hdl/cbt_back.sv
// ----------------------------------------------------------------------------
// cbt_back
// Token output stage: unpacks one queue entry into one or two tokens.
// ----------------------------------------------------------------------------
module cbt_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cbt_pkg::entry_t               head_entry,
    input  logic                          head_valid,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    token_kind,
    output logic [cbt_pkg::TOK_OFF_W-1:0] token_start,
    output logic [cbt_pkg::TOK_OFF_W-1:0] token_end,
    output logic                          offset_overflow,
    output logic                          last_of_item
);

    cbt_pkg::entry_t entry_reg;
    logic            valid_reg, valid_next;
    logic            sel_reg,   sel_next;
    logic            out_fire;
    logic            is_last;
    cbt_pkg::token_t tok;

    assign is_last  = (sel_reg == entry_reg.two_tokens);
    assign out_fire = valid_reg && !out_stall;
    assign pop      = head_valid && (!valid_reg || (out_fire && is_last));

    always_comb
    begin
        valid_next = valid_reg;
        sel_next   = sel_reg;
        if (pop)
        begin
            valid_next = 1'b1;
            sel_next   = 1'b0;
        end
        else if (out_fire && is_last)
        begin
            valid_next = 1'b0;
        end
        else if (out_fire)
        begin
            sel_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            entry_reg <= head_entry;
        end
    end

    assign tok             = sel_reg ? entry_reg.tok1 : entry_reg.tok0;
    assign out_valid       = valid_reg;
    assign token_kind      = tok.kind;
    assign token_start     = tok.tok_start;
    assign token_end       = tok.tok_end;
    assign offset_overflow = tok.ovf;
    assign last_of_item    = is_last;

endmodule
